>>> src/sld_pkg.sv
// Shared types and constants of the liveness dataflow engine.
`timescale 1ns / 1ps

package sld_pkg;

	localparam int unsigned NumBlocks = 32;
	localparam int unsigned NumVregs  = 64;
	localparam int unsigned BlkW      = $clog2(NumBlocks);
	localparam int unsigned VregIdW   = 6;
	localparam int unsigned CfgW      = 6;
	localparam int unsigned ActW      = 3;

	typedef enum logic [ActW-1:0] {
		ACT_CLEAR   = 3'd0,
		ACT_PHI_DEF = 3'd1,
		ACT_PHI_IN  = 3'd2,
		ACT_BODY    = 3'd3,
		ACT_EDGE    = 3'd4,
		ACT_REACH   = 3'd5,
		ACT_RUN     = 3'd6
	} action_t;

	typedef logic [NumVregs-1:0] vset_t;

	typedef struct packed {
		logic            load;
		logic            live_clr;
		logic            pass_start;
		logic            acc_init;
		logic            acc_step;
		logic            commit;
		logic            emit;
		logic [BlkW-1:0] blk;
		logic [BlkW-1:0] idx;
		logic            last;
	} sld_cmd_t;

	typedef struct packed {
		logic reach;
		logic changed;
		logic out_free;
	} sld_sts_t;

endpackage

>>> src/sld_req_if.sv
// Request channel carrying one load, clear or run item.
`timescale 1ns / 1ps

interface sld_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [4:0] block;
	logic [4:0] target_block;
	logic       use_a_valid;
	logic [5:0] use_a;
	logic       use_b_valid;
	logic [5:0] use_b;
	logic       def_valid;
	logic [5:0] def_reg;

	modport source (
		output valid, action, block, target_block, use_a_valid, use_a,
		       use_b_valid, use_b, def_valid, def_reg,
		input  ready
	);
	modport sink (
		input  valid, action, block, target_block, use_a_valid, use_a,
		       use_b_valid, use_b, def_valid, def_reg,
		output ready
	);
endinterface

>>> src/sld_rsp_if.sv
// Response channel carrying the live sets of one block.
`timescale 1ns / 1ps

interface sld_rsp_if;
	logic        valid;
	logic        ready;
	logic [4:0]  out_block;
	logic [63:0] live_in_set;
	logic [63:0] live_out_set;
	logic        last;

	modport source (
		output valid, out_block, live_in_set, live_out_set, last,
		input  ready
	);
	modport sink (
		input  valid, out_block, live_in_set, live_out_set, last,
		output ready
	);
endinterface

>>> src/sld_ctrl.sv
// Sequencer that walks blocks and successors during a solve and the emit sweep.
`timescale 1ns / 1ps

module sld_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sld_pkg::CfgW-1:0]      cfg_wdata,
	input  logic                          req_valid,
	input  logic [sld_pkg::ActW-1:0]      req_action,
	output logic                          req_ready,
	output sld_pkg::sld_cmd_t             cmd,
	input  sld_pkg::sld_sts_t             sts
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_BLK,
		ST_SUCC,
		ST_COMMIT,
		ST_NEXT,
		ST_EMIT
	} state_t;

	state_t                      state_q;
	logic [sld_pkg::CfgW-1:0]    count_q;
	logic [sld_pkg::BlkW-1:0]    blk_q;
	logic [sld_pkg::BlkW-1:0]    idx_q;
	logic [sld_pkg::BlkW-1:0]    last_idx;
	logic                        is_run;

	// Highest block in use: zero acts as one, large values saturate.
	always_comb begin
		if (count_q == '0) begin
			last_idx = '0;
		end else if (count_q > sld_pkg::CfgW'(sld_pkg::NumBlocks)) begin
			last_idx = sld_pkg::BlkW'(sld_pkg::NumBlocks - 1);
		end else begin
			last_idx = sld_pkg::BlkW'(count_q - 1'b1);
		end
	end

	assign is_run    = (req_action == sld_pkg::ACT_RUN);
	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.blk        = blk_q;
		cmd.idx        = idx_q;
		cmd.last       = (idx_q == last_idx);
		cmd.load       = (state_q == ST_IDLE) && req_valid && !is_run;
		cmd.live_clr   = (state_q == ST_INIT);
		cmd.pass_start = (state_q == ST_INIT) ||
		                 ((state_q == ST_NEXT) && (blk_q == '0) && sts.changed);
		cmd.acc_init   = (state_q == ST_BLK);
		cmd.acc_step   = (state_q == ST_SUCC);
		cmd.commit     = (state_q == ST_COMMIT);
		cmd.emit       = (state_q == ST_EMIT) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= sld_pkg::CfgW'(sld_pkg::NumBlocks);
			blk_q   <= '0;
			idx_q   <= '0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid && is_run) begin
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					blk_q   <= last_idx;
					state_q <= ST_BLK;
				end
				ST_BLK: begin
					idx_q   <= '0;
					state_q <= sts.reach ? ST_SUCC : ST_NEXT;
				end
				ST_SUCC: begin
					if (idx_q == last_idx) begin
						state_q <= ST_COMMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_COMMIT: begin
					state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					if (blk_q != '0) begin
						blk_q   <= blk_q - 1'b1;
						state_q <= ST_BLK;
					end else if (sts.changed) begin
						blk_q   <= last_idx;
						state_q <= ST_BLK;
					end else begin
						idx_q   <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (sts.out_free) begin
						if (idx_q == last_idx) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> src/sld_dpath.sv
// Fact tables, live set tables, accumulator and output register.
`timescale 1ns / 1ps

module sld_dpath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sld_pkg::sld_cmd_t               cmd,
	output sld_pkg::sld_sts_t               sts,
	input  logic [sld_pkg::ActW-1:0]        req_action,
	input  logic [sld_pkg::BlkW-1:0]        req_block,
	input  logic [sld_pkg::BlkW-1:0]        req_target_block,
	input  logic                            req_use_a_valid,
	input  logic [sld_pkg::VregIdW-1:0]     req_use_a,
	input  logic                            req_use_b_valid,
	input  logic [sld_pkg::VregIdW-1:0]     req_use_b,
	input  logic                            req_def_valid,
	input  logic [sld_pkg::VregIdW-1:0]     req_def_reg,
	input  logic                            rsp_ready,
	output logic                            rsp_valid,
	output logic [sld_pkg::BlkW-1:0]        rsp_out_block,
	output sld_pkg::vset_t                  rsp_live_in_set,
	output sld_pkg::vset_t                  rsp_live_out_set,
	output logic                            rsp_last
);

	sld_pkg::vset_t                  up_q   [sld_pkg::NumBlocks];
	sld_pkg::vset_t                  kill_q [sld_pkg::NumBlocks];
	sld_pkg::vset_t                  phi_q  [sld_pkg::NumBlocks];
	sld_pkg::vset_t                  lin_q  [sld_pkg::NumBlocks];
	sld_pkg::vset_t                  lout_q [sld_pkg::NumBlocks];
	logic [sld_pkg::NumBlocks-1:0]   succ_q [sld_pkg::NumBlocks];
	logic [sld_pkg::NumBlocks-1:0]   reach_q;
	logic                            changed_q;
	sld_pkg::vset_t                  acc_q;
	logic                            out_valid_q;

	logic [sld_pkg::BlkW-1:0]        rblk;
	logic [sld_pkg::BlkW-1:0]        lrd;
	sld_pkg::vset_t                  up_r, kill_r, phi_r, lin_r, lout_r;
	sld_pkg::vset_t                  a_bit, b_bit, d_bit, nin;
	logic                            diff;

	function automatic sld_pkg::vset_t reg_bit(input logic vld,
	                                           input logic [sld_pkg::VregIdW-1:0] id);
		sld_pkg::vset_t m;
		m = '0;
		if (vld && (32'(id) < sld_pkg::NumVregs)) begin
			m[id] = 1'b1;
		end
		return m;
	endfunction

	assign rblk   = cmd.load ? req_block : cmd.blk;
	assign up_r   = up_q[rblk];
	assign kill_r = kill_q[rblk];
	assign phi_r  = phi_q[rblk];
	assign lrd    = cmd.commit ? cmd.blk : cmd.idx;
	assign lin_r  = lin_q[lrd];
	assign lout_r = lout_q[lrd];

	assign a_bit = reg_bit(req_use_a_valid, req_use_a);
	assign b_bit = reg_bit(req_use_b_valid, req_use_b);
	assign d_bit = reg_bit(req_def_valid, req_def_reg);

	assign nin  = up_r | (acc_q & ~kill_r);
	assign diff = (nin != lin_r) || (acc_q != lout_r);

	assign sts.reach    = reach_q[cmd.blk];
	assign sts.changed  = changed_q;
	assign sts.out_free = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sld_pkg::NumBlocks; i++) begin
				up_q[i]   <= '0;
				kill_q[i] <= '0;
				phi_q[i]  <= '0;
				lin_q[i]  <= '0;
				lout_q[i] <= '0;
				succ_q[i] <= '0;
			end
			reach_q     <= '0;
			changed_q   <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				case (req_action)
					sld_pkg::ACT_CLEAR: begin
						for (int i = 0; i < sld_pkg::NumBlocks; i++) begin
							up_q[i]   <= '0;
							kill_q[i] <= '0;
							phi_q[i]  <= '0;
							lin_q[i]  <= '0;
							lout_q[i] <= '0;
							succ_q[i] <= '0;
						end
						reach_q   <= '0;
						changed_q <= 1'b0;
					end
					sld_pkg::ACT_PHI_DEF: begin
						kill_q[rblk] <= kill_r | d_bit;
					end
					sld_pkg::ACT_PHI_IN: begin
						phi_q[rblk] <= phi_r | a_bit;
					end
					sld_pkg::ACT_BODY: begin
						up_q[rblk]   <= up_r | ((a_bit | b_bit) & ~kill_r);
						kill_q[rblk] <= kill_r | d_bit;
					end
					sld_pkg::ACT_EDGE: begin
						succ_q[rblk][req_target_block] <= 1'b1;
					end
					sld_pkg::ACT_REACH: begin
						reach_q[rblk] <= 1'b1;
					end
					default: begin
					end
				endcase
			end
			if (cmd.live_clr) begin
				for (int i = 0; i < sld_pkg::NumBlocks; i++) begin
					lin_q[i]  <= '0;
					lout_q[i] <= '0;
				end
			end
			if (cmd.pass_start) begin
				changed_q <= 1'b0;
			end
			if (cmd.acc_init) begin
				acc_q <= phi_r;
			end
			if (cmd.acc_step && succ_q[cmd.blk][cmd.idx]) begin
				acc_q <= acc_q | lin_r;
			end
			if (cmd.commit && diff) begin
				lin_q[cmd.blk]  <= nin;
				lout_q[cmd.blk] <= acc_q;
				changed_q       <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_out_block    <= cmd.idx;
			rsp_live_in_set  <= lin_r;
			rsp_live_out_set <= lout_r;
			rsp_last         <= cmd.last;
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

>>> src/ssa_liveness_dataflow_core.sv
// Top level of the backward liveness dataflow engine.
`timescale 1ns / 1ps
// Clear, phi, body, edge and reachable requests are applied as they are taken.
// A run request solves in passes from the highest block in use down, N the block
// count: a reachable block steps through all N successor slots, an unreachable
// one is skipped. Once a pass changes nothing, the N blocks are emitted in order.
// Throughput is set by the single successor-merge step, one successor a cycle.
// Reset (arst_n low, asynchronous) clears all tables and sets block_count to 32.

module ssa_liveness_dataflow_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [sld_pkg::CfgW-1:0]  cfg_wdata,
	sld_req_if.sink                   req,
	sld_rsp_if.source                 rsp
);

	// The controller owns the block count register, the block and successor
	// counters and the sequencing of a solve. The datapath owns every table:
	// upward-exposed, kill and phi-edge sets, successor and reachable masks,
	// the live sets, the change flag, the live-out accumulator and the output
	// register. They talk only through the command and status structs.
	sld_pkg::sld_cmd_t cmd;
	sld_pkg::sld_sts_t sts;

	sld_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_valid  (req.valid),
		.req_action (req.action),
		.req_ready  (req.ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	// A solve walks blocks from the highest in use down to zero. For each
	// reachable block the accumulator starts from the phi-edge uses and then
	// merges the live-in set of every successor, one per cycle. The commit
	// step forms the new live-in; on any difference it writes both and notes a change.
	// The output register lets the engine take the next request while the
	// final response of a run still waits for the consumer.
	sld_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.req_action       (req.action),
		.req_block        (req.block),
		.req_target_block (req.target_block),
		.req_use_a_valid  (req.use_a_valid),
		.req_use_a        (req.use_a),
		.req_use_b_valid  (req.use_b_valid),
		.req_use_b        (req.use_b),
		.req_def_valid    (req.def_valid),
		.req_def_reg      (req.def_reg),
		.rsp_ready        (rsp.ready),
		.rsp_valid        (rsp.valid),
		.rsp_out_block    (rsp.out_block),
		.rsp_live_in_set  (rsp.live_in_set),
		.rsp_live_out_set (rsp.live_out_set),
		.rsp_last         (rsp.last)
	);

endmodule

>>> src/sld_checker.sv
// Port-level checks of the liveness engine and their binding to the top level.
`timescale 1ns / 1ps

module sld_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic [2:0]  req_action,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [4:0]  rsp_out_block,
	input logic [63:0] rsp_live_in_set,
	input logic [63:0] rsp_live_out_set,
	input logic        rsp_last
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_block) &&
			$stable(rsp_live_in_set) && $stable(rsp_live_out_set) && $stable(rsp_last))
		else $error("response changed while stalled");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !rsp_valid)
		else $error("response valid during reset");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_action == sld_pkg::ACT_RUN) |=> !req_ready)
		else $error("request taken right after a run");

	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last |-> !req_ready)
		else $error("request ready in the middle of an emit sweep");

	a_emit_cont: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
		else $error("gap in the emit sweep");

endmodule

bind ssa_liveness_dataflow_core sld_checker u_sld_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.req_action       (req.action),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_out_block    (rsp.out_block),
	.rsp_live_in_set  (rsp.live_in_set),
	.rsp_live_out_set (rsp.live_out_set),
	.rsp_last         (rsp.last)
);

>>> test/testbench.sv
// Self-checking testbench for the liveness dataflow engine with its own liveness solver.
`timescale 1ns / 1ps

module testbench;

	// Action code 7 has no member in the package; the block must ignore it.
	localparam logic [sld_pkg::ActW-1:0] ACT_UNUSED = 3'd7;

	// Cycles that let a trailing load finish before the block is treated as idle.
	localparam int unsigned LoadSettle = 8;
	// Upper bound on the final wait for outstanding block reports, in cycles.
	localparam int unsigned DrainLimit = 200000;

	// One request as it travels on the request channel.
	typedef struct packed {
		logic [sld_pkg::ActW-1:0]    action;
		logic [sld_pkg::BlkW-1:0]    block;
		logic [sld_pkg::BlkW-1:0]    tgt;
		logic                        ua_v;
		logic [sld_pkg::VregIdW-1:0] ua;
		logic                        ub_v;
		logic [sld_pkg::VregIdW-1:0] ub;
		logic                        dv;
		logic [sld_pkg::VregIdW-1:0] d;
	} live_req_t;

	// One expected block report.
	typedef struct packed {
		logic [sld_pkg::BlkW-1:0] blk;
		sld_pkg::vset_t           entry_set;
		sld_pkg::vset_t           exit_set;
		logic                     last;
	} live_sets_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [sld_pkg::CfgW-1:0] cfg_wdata;

	sld_req_if req_ch ();
	sld_rsp_if rsp_ch ();

	ssa_liveness_dataflow_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Mirror of the block's fact tables and its one register.
	sld_pkg::vset_t           upward_tab [sld_pkg::NumBlocks];
	sld_pkg::vset_t           kill_tab [sld_pkg::NumBlocks];
	sld_pkg::vset_t           phi_edge_tab [sld_pkg::NumBlocks];
	logic [31:0]              succ_tab [sld_pkg::NumBlocks];
	logic [31:0]              reach_mask;
	logic [sld_pkg::CfgW-1:0] block_count_reg;

	// Block reports predicted but not yet seen, oldest first.
	live_sets_t pending_reports [$];

	int unsigned mismatch_count;
	int unsigned requests_sent;

	// Idle controls for the two sides of the block.
	bit send_gaps;
	bit recv_stalls;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: far beyond the slowest legal run of this stimulus.
	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// The block count as the block applies it: zero acts as one, large values saturate.
	function automatic int active_blocks();
		int n;
		n = int'(block_count_reg);
		if (n < 1) begin
			n = 1;
		end
		if (n > int'(sld_pkg::NumBlocks)) begin
			n = int'(sld_pkg::NumBlocks);
		end
		return n;
	endfunction

	function automatic void clear_facts();
		for (int b = 0; b < sld_pkg::NumBlocks; b++) begin
			upward_tab[b]   = '0;
			kill_tab[b]     = '0;
			phi_edge_tab[b] = '0;
			succ_tab[b]     = '0;
		end
		reach_mask = '0;
	endfunction

	// Least fixed point of the loaded facts. Live sets start from zero on every run,
	// and blocks are visited from the highest index down until a pass changes nothing.
	// Successors at or above the active count contribute an empty live_in.
	function automatic void solve_liveness();
		int             n;
		sld_pkg::vset_t lin [sld_pkg::NumBlocks];
		sld_pkg::vset_t lout [sld_pkg::NumBlocks];
		sld_pkg::vset_t nin;
		sld_pkg::vset_t nout;
		bit             changed;
		live_sets_t     rec;
		n = active_blocks();
		for (int b = 0; b < sld_pkg::NumBlocks; b++) begin
			lin[b]  = '0;
			lout[b] = '0;
		end
		do begin
			changed = 1'b0;
			for (int b = n - 1; b >= 0; b--) begin
				if (reach_mask[b]) begin
					nout = phi_edge_tab[b];
					for (int s = 0; s < n; s++) begin
						if (succ_tab[b][s]) begin
							nout |= lin[s];
						end
					end
					nin = upward_tab[b] | (nout & ~kill_tab[b]);
					if (nin != lin[b] || nout != lout[b]) begin
						lin[b]  = nin;
						lout[b] = nout;
						changed = 1'b1;
					end
				end
			end
		end while (changed);
		// Unreachable blocks are never touched above, so they report empty sets.
		for (int b = 0; b < n; b++) begin
			rec.blk       = b[sld_pkg::BlkW-1:0];
			rec.entry_set = lin[b];
			rec.exit_set  = lout[b];
			rec.last      = (b == n - 1);
			pending_reports.insert(pending_reports.size(), rec);
		end
	endfunction

	// Applies one accepted request to the mirrored tables.
	function automatic void apply_request(live_req_t r);
		case (r.action)
			sld_pkg::ACT_CLEAR: begin
				clear_facts();
			end
			sld_pkg::ACT_PHI_DEF: begin
				if (r.dv) begin
					kill_tab[r.block][r.d] = 1'b1;
				end
			end
			sld_pkg::ACT_PHI_IN: begin
				// The incoming value is live out of the predecessor named by block.
				if (r.ua_v) begin
					phi_edge_tab[r.block][r.ua] = 1'b1;
				end
			end
			sld_pkg::ACT_BODY: begin
				// Uses are checked against earlier defs before this item's own def lands.
				if (r.ua_v && !kill_tab[r.block][r.ua]) begin
					upward_tab[r.block][r.ua] = 1'b1;
				end
				if (r.ub_v && !kill_tab[r.block][r.ub]) begin
					upward_tab[r.block][r.ub] = 1'b1;
				end
				if (r.dv) begin
					kill_tab[r.block][r.d] = 1'b1;
				end
			end
			sld_pkg::ACT_EDGE: begin
				succ_tab[r.block][r.tgt] = 1'b1;
			end
			sld_pkg::ACT_REACH: begin
				reach_mask[r.block] = 1'b1;
			end
			sld_pkg::ACT_RUN: begin
				solve_liveness();
			end
			default: begin
				// The unused code leaves everything as it was.
			end
		endcase
	endfunction

	function automatic live_req_t mk_req(logic [sld_pkg::ActW-1:0] act,
			logic [sld_pkg::BlkW-1:0] blk, logic [sld_pkg::BlkW-1:0] tgt, logic ua_v,
			logic [sld_pkg::VregIdW-1:0] ua, logic ub_v, logic [sld_pkg::VregIdW-1:0] ub,
			logic dv, logic [sld_pkg::VregIdW-1:0] d);
		live_req_t r;
		r.action = act;
		r.block  = blk;
		r.tgt    = tgt;
		r.ua_v   = ua_v;
		r.ua     = ua;
		r.ub_v   = ub_v;
		r.ub     = ub;
		r.dv     = dv;
		r.d      = d;
		return r;
	endfunction

	// Every field random; callers overwrite what the scenario needs, so the fields
	// that an action ignores still carry random content.
	function automatic live_req_t random_req();
		return mk_req(sld_pkg::ActW'($urandom_range(0, 7)),
			sld_pkg::BlkW'($urandom_range(0, 31)), sld_pkg::BlkW'($urandom_range(0, 31)),
			1'($urandom_range(0, 1)), sld_pkg::VregIdW'($urandom_range(0, 63)),
			1'($urandom_range(0, 1)), sld_pkg::VregIdW'($urandom_range(0, 63)),
			1'($urandom_range(0, 1)), sld_pkg::VregIdW'($urandom_range(0, 63)));
	endfunction

	// Mostly a small pool of registers, so that uses and defs meet in one block.
	function automatic logic [sld_pkg::VregIdW-1:0] pick_vreg();
		if ($urandom_range(0, 3) == 0) begin
			return sld_pkg::VregIdW'($urandom_range(0, 63));
		end
		return sld_pkg::VregIdW'($urandom_range(0, 11));
	endfunction

	// Mostly blocks inside the active count, sometimes any block.
	function automatic logic [sld_pkg::BlkW-1:0] pick_block(int n);
		if ($urandom_range(0, 9) == 0) begin
			return sld_pkg::BlkW'($urandom_range(0, 31));
		end
		return sld_pkg::BlkW'($urandom_range(0, n - 1));
	endfunction

	// Presents one request and holds it until the block takes it. Valid is only
	// lowered for a gap; back-to-back requests keep it high, so each step sees at
	// most one assignment to it.
	task automatic send_request(live_req_t r);
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.action       <= r.action;
		req_ch.block        <= r.block;
		req_ch.target_block <= r.tgt;
		req_ch.use_a_valid  <= r.ua_v;
		req_ch.use_a        <= r.ua;
		req_ch.use_b_valid  <= r.ub_v;
		req_ch.use_b        <= r.ub;
		req_ch.def_valid    <= r.dv;
		req_ch.def_reg      <= r.d;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		apply_request(r);
		requests_sent++;
	endtask

	// Brings the block to rest: no request offered, every report in, and a settling
	// wait for a trailing load to finish.
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (pending_reports.size() != 0) begin
			@(posedge clk);
		end
		repeat (LoadSettle) @(posedge clk);
	endtask

	task automatic write_block_count(logic [sld_pkg::CfgW-1:0] value);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we          <= 1'b0;
		block_count_reg = value;
	endtask

	// A well-formed program with random content: usually a clear first, then a mix
	// of reachable marks, edges, body items and phi facts, some noise, then a run.
	task automatic run_random_program(int loads);
		int        n;
		int        pick;
		live_req_t r;
		n = active_blocks();
		if ($urandom_range(0, 4) != 0) begin
			r = random_req();
			r.action = sld_pkg::ACT_CLEAR;
			send_request(r);
		end
		for (int i = 0; i < loads; i++) begin
			r = random_req();
			r.block = pick_block(n);
			pick = $urandom_range(0, 99);
			if (pick < 14) begin
				r.action = sld_pkg::ACT_REACH;
			end else if (pick < 34) begin
				r.action = sld_pkg::ACT_EDGE;
				r.tgt    = pick_block(n);
			end else if (pick < 72) begin
				r.action = sld_pkg::ACT_BODY;
				r.ua_v   = ($urandom_range(0, 5) != 0);
				r.ua     = pick_vreg();
				r.ub_v   = ($urandom_range(0, 2) != 0);
				r.ub     = pick_vreg();
				r.dv     = ($urandom_range(0, 3) != 0);
				r.d      = pick_vreg();
			end else if (pick < 81) begin
				r.action = sld_pkg::ACT_PHI_DEF;
				r.dv     = ($urandom_range(0, 5) != 0);
				r.d      = pick_vreg();
			end else if (pick < 90) begin
				r.action = sld_pkg::ACT_PHI_IN;
				r.ua_v   = ($urandom_range(0, 5) != 0);
				r.ua     = pick_vreg();
			end
			// The remaining tenth keeps its random action: clears, stray runs and
			// the unused code land in the middle of a program.
			send_request(r);
		end
		r = random_req();
		r.action = sld_pkg::ACT_RUN;
		send_request(r);
	endtask

	// A hand-built graph with a loop (1 -> 2 -> 1), a back edge from the top block
	// to block 0, an unreachable block with an edge, ignored invalid fields, a use
	// before a def in one item, a use after a def, phi facts and the unused code.
	task automatic test_directed_graph();
		send_gaps   = 1'b1;
		recv_stalls = 1'b1;
		send_request(mk_req(sld_pkg::ACT_CLEAR, 5'd31, 5'd31,
			1'b1, 6'd63, 1'b1, 6'd63, 1'b1, 6'd63));
		send_request(mk_req(sld_pkg::ACT_PHI_DEF, 5'd2, 5'd0,
			1'b0, 6'd0, 1'b0, 6'd0, 1'b1, 6'd63));
		send_request(mk_req(sld_pkg::ACT_PHI_DEF, 5'd2, 5'd0,
			1'b0, 6'd0, 1'b0, 6'd0, 1'b0, 6'd1));
		send_request(mk_req(sld_pkg::ACT_PHI_IN, 5'd1, 5'd0,
			1'b1, 6'd5, 1'b0, 6'd0, 1'b0, 6'd0));
		send_request(mk_req(sld_pkg::ACT_PHI_IN, 5'd1, 5'd0,
			1'b0, 6'd6, 1'b0, 6'd0, 1'b0, 6'd0));
		send_request(mk_req(sld_pkg::ACT_BODY, 5'd0, 5'd0,
			1'b1, 6'd0, 1'b1, 6'd63, 1'b1, 6'd7));
		send_request(mk_req(sld_pkg::ACT_BODY, 5'd0, 5'd0,
			1'b1, 6'd7, 1'b0, 6'd63, 1'b0, 6'd62));
		send_request(mk_req(sld_pkg::ACT_BODY, 5'd2, 5'd0,
			1'b1, 6'd9, 1'b0, 6'd0, 1'b1, 6'd9));
		send_request(mk_req(sld_pkg::ACT_BODY, 5'd2, 5'd31,
			1'b0, 6'd63, 1'b0, 6'd63, 1'b0, 6'd63));
		send_request(mk_req(sld_pkg::ACT_EDGE, 5'd0, 5'd1,
			1'b0, 6'd0, 1'b0, 6'd0, 1'b0, 6'd0));
		send_request(mk_req(sld_pkg::ACT_EDGE, 5'd1, 5'd2,
			1'b0, 6'd0, 1'b0, 6'd0, 1'b0, 6'd0));
		send_request(mk_req(sld_pkg::ACT_EDGE, 5'd2, 5'd1,
			1'b0, 6'd0, 1'b0, 6'd0, 1'b0, 6'd0));
		send_request(mk_req(sld_pkg::ACT_EDGE, 5'd2, 5'd31,
			1'b0, 6'd0, 1'b0, 6'd0, 1'b0, 6'd0));
		send_request(mk_req(sld_pkg::ACT_EDGE, 5'd31, 5'd0,
			1'b0, 6'd0, 1'b0, 6'd0, 1'b0, 6'd0));
		send_request(mk_req(sld_pkg::ACT_REACH, 5'd0, 5'd0,
			1'b0, 6'd0, 1'b0, 6'd0, 1'b0, 6'd0));
		send_request(mk_req(sld_pkg::ACT_REACH, 5'd1, 5'd0,
			1'b0, 6'd0, 1'b0, 6'd0, 1'b0, 6'd0));
		send_request(mk_req(sld_pkg::ACT_REACH, 5'd2, 5'd0,
			1'b0, 6'd0, 1'b0, 6'd0, 1'b0, 6'd0));
		send_request(mk_req(sld_pkg::ACT_REACH, 5'd31, 5'd0,
			1'b0, 6'd0, 1'b0, 6'd0, 1'b0, 6'd0));
		send_request(mk_req(sld_pkg::ACT_BODY, 5'd31, 5'd0,
			1'b1, 6'd62, 1'b1, 6'd5, 1'b1, 6'd63));
		send_request(mk_req(sld_pkg::ACT_BODY, 5'd3, 5'd0,
			1'b1, 6'd40, 1'b0, 6'd0, 1'b0, 6'd0));
		send_request(mk_req(sld_pkg::ACT_EDGE, 5'd3, 5'd0,
			1'b0, 6'd0, 1'b0, 6'd0, 1'b0, 6'd0));
		send_request(mk_req(ACT_UNUSED, 5'd31, 5'd31,
			1'b1, 6'd63, 1'b1, 6'd63, 1'b1, 6'd63));
		send_request(mk_req(sld_pkg::ACT_RUN, 5'd0, 5'd0,
			1'b0, 6'd0, 1'b0, 6'd0, 1'b0, 6'd0));
		// A later phi def in block 1 kills the phi value there on entry only.
		send_request(mk_req(sld_pkg::ACT_PHI_DEF, 5'd1, 5'd0,
			1'b0, 6'd0, 1'b0, 6'd0, 1'b1, 6'd5));
		send_request(mk_req(sld_pkg::ACT_RUN, 5'd31, 5'd31,
			1'b1, 6'd63, 1'b1, 6'd63, 1'b1, 6'd63));
	endtask

	// The register at its extremes and around the saturation point, each followed
	// by a short program. Zero must act as a single block.
	task automatic test_block_count_extremes();
		logic [sld_pkg::CfgW-1:0] counts [6];
		counts = '{6'd1, 6'd0, 6'd63, 6'd33, 6'd31, 6'd32};
		foreach (counts[i]) begin
			write_block_count(counts[i]);
			run_random_program($urandom_range(8, 16));
		end
	endtask

	// Random programs under random block counts and random idling on both sides.
	task automatic test_random_programs();
		while (requests_sent < 420) begin
			if ($urandom_range(0, 2) == 0) begin
				write_block_count(sld_pkg::CfgW'($urandom_range(0, 63)));
			end
			send_gaps   = ($urandom_range(0, 3) != 0);
			recv_stalls = ($urandom_range(0, 3) != 0);
			run_random_program($urandom_range(8, 40));
		end
	endtask

	// The tail of the run: no idling, all blocks marked reachable, then a random program at full count.
	task automatic test_steady_stream();
		live_req_t r;
		write_block_count(6'd32);
		send_gaps   = 1'b0;
		recv_stalls = 1'b0;
		r = random_req();
		r.action = sld_pkg::ACT_CLEAR;
		send_request(r);
		for (int b = 0; b < sld_pkg::NumBlocks; b++) begin
			r = random_req();
			r.action = sld_pkg::ACT_REACH;
			r.block  = b[sld_pkg::BlkW-1:0];
			send_request(r);
		end
		run_random_program(40);
	endtask

	// Sink side: ready stalls in random bursts while stalls are enabled.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (recv_stalls && $urandom_range(0, 7) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	// Every accepted report is checked against the oldest prediction.
	always @(posedge clk) begin : report_check
		live_sets_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_reports.size() == 0) begin
				$error("unexpected report for block %0d", rsp_ch.out_block);
				mismatch_count++;
			end else begin
				want = pending_reports.pop_front();
				if (rsp_ch.out_block !== want.blk) begin
					$error("out_block: expected %0d, got %0d", want.blk, rsp_ch.out_block);
					mismatch_count++;
				end
				if (rsp_ch.live_in_set !== want.entry_set) begin
					$error("live_in_set: expected %h, got %h", want.entry_set,
						rsp_ch.live_in_set);
					mismatch_count++;
				end
				if (rsp_ch.live_out_set !== want.exit_set) begin
					$error("live_out_set: expected %h, got %h", want.exit_set,
						rsp_ch.live_out_set);
					mismatch_count++;
				end
				if (rsp_ch.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, rsp_ch.last);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		req_ch.valid        = 1'b0;
		req_ch.action       = '0;
		req_ch.block        = '0;
		req_ch.target_block = '0;
		req_ch.use_a_valid  = 1'b0;
		req_ch.use_a        = '0;
		req_ch.use_b_valid  = 1'b0;
		req_ch.use_b        = '0;
		req_ch.def_valid    = 1'b0;
		req_ch.def_reg      = '0;
		send_gaps           = 1'b0;
		recv_stalls         = 1'b0;
		mismatch_count      = 0;
		requests_sent       = 0;
		block_count_reg     = 6'd32;
		clear_facts();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_graph();
		test_block_count_extremes();
		test_random_programs();
		test_steady_stream();

		// Wait for the last run to drain, but not forever.
		req_ch.valid <= 1'b0;
		for (int i = 0; i < DrainLimit && pending_reports.size() != 0; i++) begin
			@(posedge clk);
		end
		repeat (LoadSettle) @(posedge clk);
		if (pending_reports.size() != 0) begin
			$error("%0d block reports never arrived", pending_reports.size());
			mismatch_count++;
		end

		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
